FILE: hdl/mrfp_pkg.sv
package mrfp_pkg;

  localparam int unsigned EventWidth = 3;

  typedef enum logic [EventWidth-1:0] {
    EV_PARSING  = 3'd0,
    EV_GARBAGE  = 3'd1,
    EV_OVERFLOW = 3'd2,
    EV_CMD      = 3'd3,
    EV_INFO     = 3'd4,
    EV_PACKET   = 3'd5
  } event_e;

  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChEquals = 8'h3D;
  localparam logic [7:0] ChD      = 8'h44;
  localparam logic [7:0] ChR      = 8'h52;
  localparam logic [7:0] ChI      = 8'h49;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChUpperF = 8'h46;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerF = 8'h66;

  // position of the second length digit in a "*DR=hh" header
  localparam int unsigned SizeLowPos = 5;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] c);
    hex_t r;
    r.ok    = 1'b1;
    r.value = 4'd0;
    if (c >= ChZero && c <= ChNine) begin
      r.value = 4'(c - ChZero);
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      r.value = 4'(c - ChLowerA + 8'd10);
    end else if (c >= ChUpperA && c <= ChUpperF) begin
      r.value = 4'(c - ChUpperA + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/modem_response_frame_parser.sv
// Modem response frame parser.
// Input channel rx_*: one received serial byte per transaction.
// Output channel res_*: exactly one result per input byte, in order, carrying
// the event code, the echo of a stored frame byte with its buffer index, and
// line or packet length on the completing byte.
// Frames: '*', two capitals, '='. "*DR=" takes a two-hex-digit length, the
// payload and CR LF; other lines end at CR LF ("*IR" gives an info event).
// Result valid is registered and rises in the cycle after the input transaction.
// Throughput: one byte per cycle when not stalled; the parser state and the
// result register are updated in the same cycle by one next-state pass.
// The result register is the only buffer: rx_ready_o is high while it is
// empty or being drained, so a stalled receiver holds the input back after
// one result is waiting.
// Reset (rst_ni low, asynchronous): parser idle, all counters zero, no result
// pending.
module modem_response_frame_parser
  import mrfp_pkg::*;
#(
  parameter int unsigned LINE_BUFFER_SIZE = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rx_valid_i,
  output logic                  rx_ready_o,
  input  logic [7:0]            rx_byte_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [EventWidth-1:0] event_res_o,
  output logic                  echo_valid_o,
  output logic                  echo_target_o,
  output logic [8:0]            echo_index_o,
  output logic [7:0]            echo_byte_o,
  output logic [5:0]            line_length_o,
  output logic [7:0]            packet_length_o
);

  localparam int unsigned PosWidth = $clog2(LINE_BUFFER_SIZE + 1);
  localparam logic [PosWidth-1:0] PosLimit = PosWidth'(LINE_BUFFER_SIZE);

  typedef enum logic [2:0] {
    PH_IDLE, PH_FIRST, PH_SECOND, PH_EQUALS, PH_SIZE, PH_PAYLOAD, PH_TEXT, PH_LF
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [7:0]          first_q, first_d;
  logic [7:0]          second_q, second_d;
  logic [7:0]          hi_digit_q, hi_digit_d;
  logic [7:0]          exp_len_q, exp_len_d;
  logic [8:0]          pay_cnt_q, pay_cnt_d;
  logic [7:0]          prev_byte_q, prev_byte_d;

  event_e              ev;
  logic                ev_valid, tgt, restart;
  logic [8:0]          idx;
  logic [5:0]          llen;
  logic [7:0]          plen;
  logic [PosWidth-1:0] pos_inc;
  logic [8:0]          llen_full;
  hex_t                hex_hi, hex_lo;

  logic rx_fire;

  assign rx_ready_o = !res_valid_o || res_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  assign pos_inc   = pos_q + PosWidth'(1);
  assign llen_full = 9'(pos_q) - 9'd1;
  assign hex_hi    = hex_decode(hi_digit_q);
  assign hex_lo    = hex_decode(rx_byte_i);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    first_d     = first_q;
    second_d    = second_q;
    hi_digit_d  = hi_digit_q;
    exp_len_d   = exp_len_q;
    pay_cnt_d   = pay_cnt_q;
    prev_byte_d = prev_byte_q;
    ev          = EV_PARSING;
    ev_valid    = 1'b0;
    tgt         = 1'b0;
    idx         = 9'd0;
    llen        = 6'd0;
    plen        = 8'd0;
    restart     = 1'b0;

    case (phase_q)
      PH_IDLE: begin
        if (rx_byte_i == ChStar) begin
          ev_valid = 1'b1;
          pos_d    = PosWidth'(1);
          phase_d  = PH_FIRST;
        end
      end
      PH_FIRST, PH_SECOND: begin
        if (rx_byte_i >= ChUpperA && rx_byte_i <= ChUpperZ) begin
          ev_valid = 1'b1;
          idx      = 9'(pos_q);
          pos_d    = pos_inc;
          if (phase_q == PH_FIRST) begin
            first_d = rx_byte_i;
            phase_d = PH_SECOND;
          end else begin
            second_d = rx_byte_i;
            phase_d  = PH_EQUALS;
          end
        end else begin
          ev      = EV_GARBAGE;
          restart = (rx_byte_i == ChStar);
        end
      end
      PH_EQUALS: begin
        if (rx_byte_i == ChEquals) begin
          ev_valid = 1'b1;
          idx      = 9'(pos_q);
          pos_d    = pos_inc;
          phase_d  = (first_q == ChD && second_q == ChR) ? PH_SIZE : PH_TEXT;
        end else begin
          ev      = EV_GARBAGE;
          restart = (rx_byte_i == ChStar);
        end
      end
      PH_SIZE: begin
        if (9'(pos_q) < 9'(SizeLowPos)) begin
          ev_valid   = 1'b1;
          idx        = 9'(pos_q);
          hi_digit_d = rx_byte_i;
          pos_d      = pos_inc;
        end else if (hex_hi.ok && hex_lo.ok) begin
          ev_valid  = 1'b1;
          idx       = 9'(pos_q);
          pos_d     = pos_inc;
          exp_len_d = {hex_hi.value, hex_lo.value};
          pay_cnt_d = 9'd0;
          phase_d   = PH_PAYLOAD;
        end else begin
          ev = EV_GARBAGE;
        end
      end
      PH_PAYLOAD: begin
        idx         = pay_cnt_q;
        pay_cnt_d   = pay_cnt_q + 9'd1;
        prev_byte_d = rx_byte_i;
        if (pay_cnt_d == 9'(exp_len_q) + 9'd2) begin
          if (prev_byte_q == ChCr && rx_byte_i == ChLf) begin
            ev_valid = 1'b1;
            tgt      = 1'b1;
            ev       = EV_PACKET;
            plen     = exp_len_q;
            phase_d  = PH_IDLE;
          end else begin
            ev = EV_GARBAGE;
          end
        end else begin
          ev_valid = 1'b1;
          tgt      = 1'b1;
        end
      end
      PH_TEXT: begin
        if (rx_byte_i == ChLf || rx_byte_i == ChStar) begin
          ev      = EV_GARBAGE;
          restart = (rx_byte_i == ChStar);
        end else begin
          idx   = 9'(pos_q);
          pos_d = pos_inc;
          if (pos_inc >= PosLimit) begin
            ev      = EV_OVERFLOW;
            phase_d = PH_IDLE;
          end else begin
            ev_valid = 1'b1;
            if (rx_byte_i == ChCr) begin
              phase_d = PH_LF;
            end
          end
        end
      end
      PH_LF: begin
        if (rx_byte_i == ChLf) begin
          ev_valid = 1'b1;
          idx      = 9'(pos_q);
          llen     = llen_full[5:0];
          ev       = (first_q == ChI && second_q == ChR) ? EV_INFO : EV_CMD;
          phase_d  = PH_IDLE;
        end else begin
          ev      = EV_GARBAGE;
          restart = (rx_byte_i == ChStar);
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // a stray '*' reopens a frame
    if (ev == EV_GARBAGE) begin
      if (restart) begin
        ev_valid = 1'b1;
        tgt      = 1'b0;
        idx      = 9'd0;
        pos_d    = PosWidth'(1);
        phase_d  = PH_FIRST;
      end else begin
        phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pos_q       <= '0;
      first_q     <= '0;
      second_q    <= '0;
      hi_digit_q  <= '0;
      exp_len_q   <= '0;
      pay_cnt_q   <= '0;
      prev_byte_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      if (rx_fire) begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        first_q     <= first_d;
        second_q    <= second_d;
        hi_digit_q  <= hi_digit_d;
        exp_len_q   <= exp_len_d;
        pay_cnt_q   <= pay_cnt_d;
        prev_byte_q <= prev_byte_d;
      end
      if (rx_fire) begin
        res_valid_o <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      event_res_o     <= ev;
      echo_valid_o    <= ev_valid;
      echo_target_o   <= ev_valid ? tgt : 1'b0;
      echo_index_o    <= ev_valid ? idx : 9'd0;
      echo_byte_o     <= ev_valid ? rx_byte_i : 8'd0;
      line_length_o   <= llen;
      packet_length_o <= plen;
    end
  end

endmodule

FILE: hdl/mrfp_checker.sv
module mrfp_checker
  import mrfp_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  rx_valid_i,
  input logic                  rx_ready_o,
  input logic                  res_valid_o,
  input logic                  res_ready_i,
  input logic [EventWidth-1:0] event_res_o,
  input logic                  echo_valid_o,
  input logic                  echo_target_o,
  input logic [8:0]            echo_index_o,
  input logic [7:0]            echo_byte_o
);

  // a waiting result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(event_res_o))
    else $error("result dropped or changed while stalled");

  // every accepted byte yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && rx_ready_o |=> res_valid_o)
    else $error("no result after input transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !echo_valid_o |->
      echo_index_o == 9'd0 && echo_byte_o == 8'd0 && !echo_target_o)
    else $error("echo fields set without echo");

  // a finished line echoes its LF into the line buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (event_res_o == EV_CMD || event_res_o == EV_INFO) |->
      echo_valid_o && !echo_target_o && echo_byte_o == ChLf)
    else $error("line end without LF echo");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && event_res_o == EV_PACKET |->
      echo_valid_o && echo_target_o && echo_byte_o == ChLf)
    else $error("packet end without payload echo");

endmodule

bind modem_response_frame_parser mrfp_checker u_mrfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rx_valid_i   (rx_valid_i),
  .rx_ready_o   (rx_ready_o),
  .res_valid_o  (res_valid_o),
  .res_ready_i  (res_ready_i),
  .event_res_o  (event_res_o),
  .echo_valid_o (echo_valid_o),
  .echo_target_o(echo_target_o),
  .echo_index_o (echo_index_o),
  .echo_byte_o  (echo_byte_o)
);

FILE: dv/tb_modem_response_frame_parser.sv
module tb_modem_response_frame_parser;
  import mrfp_pkg::*;

  localparam int unsigned LineBufSize = 64;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned LongHoldAt  = 300;
  localparam int unsigned LongHoldLen = 400;
  localparam int unsigned MaxPrinted  = 50;

  typedef enum logic [2:0] {
    IDLE_WAIT, GET_FIRST, GET_SECOND, GET_EQUALS,
    GET_SIZE, GET_PAYLOAD, GET_TEXT, GET_LF
  } frame_phase_e;

  typedef struct packed {
    event_e     ev;
    logic       echo_valid;
    logic       echo_target;
    logic [8:0] echo_index;
    logic [7:0] echo_byte;
    logic [5:0] line_length;
    logic [7:0] packet_length;
  } frame_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  rx_valid = 1'b0;
  logic [7:0]            rx_byte = 8'h00;
  logic                  res_ready = 1'b0;
  logic                  rx_ready_o;
  logic                  res_valid_o;
  logic [EventWidth-1:0] event_res_o;
  logic                  echo_valid_o;
  logic                  echo_target_o;
  logic [8:0]            echo_index_o;
  logic [7:0]            echo_byte_o;
  logic [5:0]            line_length_o;
  logic [7:0]            packet_length_o;

  // parser shadow state
  frame_phase_e phase;
  logic [6:0]   line_pos;
  logic [7:0]   letter_a;
  logic [7:0]   letter_b;
  logic [7:0]   size_hi;
  logic [7:0]   pkt_len;
  logic [8:0]   pay_cnt;
  logic [7:0]   last_pay;

  logic [7:0]    pending_bytes[$];
  frame_result_t expected_results[$];

  int  bytes_queued = 0;
  int  rx_taken = 0;
  int  res_seen = 0;
  int  err_count = 0;
  int  drv_gap = 0;
  int  mon_gap = 0;
  int  quiet_cycles = 0;
  bit  idling_on = 1'b1;
  bit  long_hold_done = 1'b0;

  logic          offer;
  logic [7:0]    offer_byte;
  logic          take_res;
  frame_result_t want;

  modem_response_frame_parser #(
    .LINE_BUFFER_SIZE(LineBufSize)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready),
    .event_res_o    (event_res_o),
    .echo_valid_o   (echo_valid_o),
    .echo_target_o  (echo_target_o),
    .echo_index_o   (echo_index_o),
    .echo_byte_o    (echo_byte_o),
    .line_length_o  (line_length_o),
    .packet_length_o(packet_length_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // {ok, value}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= ChZero && c <= ChNine) begin
      return {1'b1, 4'(c - ChZero)};
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      return {1'b1, 4'(c - ChLowerA + 8'd10)};
    end else if (c >= ChUpperA && c <= ChUpperF) begin
      return {1'b1, 4'(c - ChUpperA + 8'd10)};
    end
    return 5'd0;
  endfunction

  function automatic frame_result_t parse_byte(input logic [7:0] b);
    frame_result_t r;
    logic          restart;
    logic [4:0]    hi;
    logic [4:0]    lo;
    r = '0;
    r.ev = EV_PARSING;
    restart = 1'b0;
    case (phase)
      IDLE_WAIT: begin
        if (b == ChStar) begin
          r.echo_valid = 1'b1;
          line_pos = 7'd1;
          phase = GET_FIRST;
        end
      end
      GET_FIRST, GET_SECOND: begin
        if (b >= ChUpperA && b <= ChUpperZ) begin
          r.echo_valid = 1'b1;
          r.echo_index = 9'(line_pos);
          if (phase == GET_FIRST) begin
            letter_a = b;
            phase = GET_SECOND;
          end else begin
            letter_b = b;
            phase = GET_EQUALS;
          end
          line_pos = line_pos + 7'd1;
        end else begin
          r.ev = EV_GARBAGE;
          restart = (b == ChStar);
        end
      end
      GET_EQUALS: begin
        if (b == ChEquals) begin
          r.echo_valid = 1'b1;
          r.echo_index = 9'(line_pos);
          line_pos = line_pos + 7'd1;
          phase = (letter_a == ChD && letter_b == ChR) ? GET_SIZE : GET_TEXT;
        end else begin
          r.ev = EV_GARBAGE;
          restart = (b == ChStar);
        end
      end
      GET_SIZE: begin
        if (line_pos < 7'(SizeLowPos)) begin
          r.echo_valid = 1'b1;
          r.echo_index = 9'(line_pos);
          size_hi = b;
          line_pos = line_pos + 7'd1;
        end else begin
          hi = nibble_of(size_hi);
          lo = nibble_of(b);
          if (hi[4] && lo[4]) begin
            r.echo_valid = 1'b1;
            r.echo_index = 9'(line_pos);
            line_pos = line_pos + 7'd1;
            pkt_len = {hi[3:0], lo[3:0]};
            pay_cnt = 9'd0;
            phase = GET_PAYLOAD;
          end else begin
            r.ev = EV_GARBAGE;
          end
        end
      end
      GET_PAYLOAD: begin
        r.echo_index = pay_cnt;
        pay_cnt = pay_cnt + 9'd1;
        if (int'(pay_cnt) == int'(pkt_len) + 2) begin
          if (last_pay == ChCr && b == ChLf) begin
            r.echo_valid = 1'b1;
            r.echo_target = 1'b1;
            r.ev = EV_PACKET;
            r.packet_length = pkt_len;
            phase = IDLE_WAIT;
          end else begin
            r.ev = EV_GARBAGE;
          end
        end else begin
          r.echo_valid = 1'b1;
          r.echo_target = 1'b1;
        end
        last_pay = b;
      end
      GET_TEXT: begin
        if (b == ChLf || b == ChStar) begin
          r.ev = EV_GARBAGE;
          restart = (b == ChStar);
        end else begin
          r.echo_index = 9'(line_pos);
          line_pos = line_pos + 7'd1;
          if (int'(line_pos) >= LineBufSize) begin
            r.ev = EV_OVERFLOW;
            phase = IDLE_WAIT;
          end else begin
            r.echo_valid = 1'b1;
            if (b == ChCr) phase = GET_LF;
          end
        end
      end
      default: begin
        if (b == ChLf) begin
          r.echo_valid = 1'b1;
          r.echo_index = 9'(line_pos);
          r.line_length = 6'(line_pos - 7'd1);
          r.ev = (letter_a == ChI && letter_b == ChR) ? EV_INFO : EV_CMD;
          phase = IDLE_WAIT;
        end else begin
          r.ev = EV_GARBAGE;
          restart = (b == ChStar);
        end
      end
    endcase
    if (r.ev == EV_GARBAGE) begin
      if (restart) begin
        // the offending star opens the next frame
        r.echo_valid = 1'b1;
        r.echo_target = 1'b0;
        r.echo_index = 9'd0;
        line_pos = 7'd1;
        phase = GET_FIRST;
      end else begin
        phase = IDLE_WAIT;
      end
    end
    if (r.echo_valid) begin
      r.echo_byte = b;
    end else begin
      r.echo_target = 1'b0;
      r.echo_index = 9'd0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    err_count++;
    if (err_count <= MaxPrinted) begin
      $display("mismatch: result %0d %s got %0d want %0d", res_seen, what, got, exp_val);
    end
  endtask

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return ChZero + 8'(n);
    return ($urandom_range(0, 1) ? ChUpperA : ChLowerA) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == ChCr || c == ChLf || c == ChStar);
    return c;
  endfunction

  function automatic logic [7:0] spicy_char();
    case ($urandom_range(0, 9))
      0: return ChStar;
      1: return ChD;
      2: return ChR;
      3: return ChEquals;
      4: return ChCr;
      5: return ChLf;
      6: return ChZero;
      7: return ChUpperF;
      8: return ChI;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_packet(input int len, input bit good_end);
    push_byte(ChStar);
    push_byte(ChD);
    push_byte(ChR);
    push_byte(ChEquals);
    push_byte(hex_char(len[7:4]));
    push_byte(hex_char(len[3:0]));
    repeat (len) push_byte(8'($urandom_range(0, 255)));
    if (good_end) begin
      push_byte(ChCr);
      push_byte(ChLf);
    end else begin
      push_byte($urandom_range(0, 1) ? ChCr : 8'($urandom_range(0, 255)));
      push_byte($urandom_range(0, 1) ? ChLf : spicy_char());
    end
  endtask

  task automatic queue_line(input logic [7:0] l1, input logic [7:0] l2, input int len,
                            input bit good_end);
    push_byte(ChStar);
    push_byte(l1);
    push_byte(l2);
    push_byte(ChEquals);
    repeat (len) push_byte(text_char());
    if (good_end) begin
      push_byte(ChCr);
      push_byte(ChLf);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          push_byte(ChCr);
          push_byte(spicy_char());
        end
        1: push_byte(ChStar);
        2: push_byte(ChLf);
        default: ;
      endcase
    end
  endtask

  task automatic queue_broken();
    case ($urandom_range(0, 3))
      0: begin
        push_byte(ChStar);
        push_byte(ChD);
        push_byte(ChR);
        push_byte(ChEquals);
        repeat (2) begin
          push_byte($urandom_range(0, 1) ? hex_char(4'($urandom_range(0, 15)))
                                         : 8'($urandom_range(0, 255)));
        end
      end
      1: begin
        push_byte(ChStar);
        repeat ($urandom_range(2, 8)) push_byte(spicy_char());
      end
      2: begin
        push_byte(ChStar);
        push_byte(8'($urandom_range(ChUpperA, ChUpperZ)));
        push_byte(ChStar);
      end
      default: begin
        push_byte(ChStar);
        push_byte(8'($urandom_range(ChUpperA, ChUpperZ)));
        push_byte(8'($urandom_range(ChUpperA, ChUpperZ)));
        push_byte(ChEquals);
        repeat ($urandom_range(0, 4)) push_byte(text_char());
        push_byte(ChCr);
        push_byte(spicy_char());
      end
    endcase
  endtask

  task automatic queue_random_block(input int n_bytes);
    int stop_at;
    int kind;
    int len;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        if ($urandom_range(0, 19) == 0) begin
          len = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(17, 255);
        end else begin
          len = $urandom_range(0, 16);
        end
        queue_packet(len, $urandom_range(0, 9) != 0);
      end else if (kind < 70) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(55, 70) : $urandom_range(0, 20);
        if (kind < 55) begin
          queue_line(8'($urandom_range(ChUpperA, ChUpperZ)),
                     8'($urandom_range(ChUpperA, ChUpperZ)), len, $urandom_range(0, 9) != 0);
        end else begin
          queue_line(ChI, ChR, len, $urandom_range(0, 9) != 0);
        end
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        queue_broken();
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      offer = rx_valid;
      offer_byte = rx_byte;
      if (rx_valid && rx_ready_o) begin
        expected_results.push_back(parse_byte(rx_byte));
        void'(pending_bytes.pop_front());
        rx_taken++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_bytes.size() != 0) begin
          if (idling_on && $urandom_range(0, 7) == 0) begin
            drv_gap = $urandom_range(0, 13);
          end else begin
            offer = 1'b1;
            offer_byte = pending_bytes[0];
          end
        end
      end
      rx_valid <= offer;
      rx_byte <= offer_byte;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && res_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, event", event_res_o, -1);
        end else begin
          want = expected_results.pop_front();
          if (event_res_o !== want.ev) report_mismatch("event_res", event_res_o, want.ev);
          if (echo_valid_o !== want.echo_valid)
            report_mismatch("echo_valid", echo_valid_o, want.echo_valid);
          if (echo_target_o !== want.echo_target)
            report_mismatch("echo_target", echo_target_o, want.echo_target);
          if (echo_index_o !== want.echo_index)
            report_mismatch("echo_index", echo_index_o, want.echo_index);
          if (echo_byte_o !== want.echo_byte)
            report_mismatch("echo_byte", echo_byte_o, want.echo_byte);
          if (line_length_o !== want.line_length)
            report_mismatch("line_length", line_length_o, want.line_length);
          if (packet_length_o !== want.packet_length)
            report_mismatch("packet_length", packet_length_o, want.packet_length);
        end
        res_seen++;
      end
      // long back-pressure once, while the sender keeps offering
      if (!long_hold_done && rx_taken >= LongHoldAt) begin
        long_hold_done = 1'b1;
        mon_gap = LongHoldLen;
      end
      if (mon_gap > 0) begin
        mon_gap--;
        take_res = 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        mon_gap = $urandom_range(0, 13);
        take_res = 1'b0;
      end else begin
        take_res = 1'b1;
      end
      res_ready <= take_res;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_valid && rx_ready_o) || (res_valid_o && res_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    phase = IDLE_WAIT;
    line_pos = 7'd0;
    letter_a = 8'h00;
    letter_b = 8'h00;
    size_hi = 8'h00;
    pkt_len = 8'h00;
    pay_cnt = 9'd0;
    last_pay = 8'h00;

    // info line, empty packet, idle noise, star restart inside the letters
    push_byte(ChStar);
    push_byte(ChI);
    push_byte(ChR);
    push_byte(ChEquals);
    push_byte(ChCr);
    push_byte(ChLf);
    queue_packet(0, 1'b1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(ChStar);
    push_byte(ChUpperA);
    push_byte(ChStar);
    push_byte(8'h42);
    push_byte(8'h43);
    push_byte(ChEquals);
    push_byte(ChCr);
    push_byte(ChLf);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_drained();
    queue_random_block(700);
    wait_drained();
    queue_random_block(650);
    wait_drained();
    idling_on = 1'b0;
    queue_random_block(300);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch("results still outstanding", 0, expected_results.size());
    end
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
